### rtl/core/waypoint_follow_steering_assert.svh
// Assertion macros shared by the steering block's modules.
// Both expect a signal named clk in the including module; WFS_ASSERT also rst_n.
`ifndef WAYPOINT_FOLLOW_STEERING_ASSERT_SVH
`define WAYPOINT_FOLLOW_STEERING_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define WFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define WFS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/wfs_pkg.sv
// ----------------------------------------------------------------------------
// wfs_pkg
// Types, codes and fixed-point constants of the waypoint steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package wfs_pkg;

    // Transaction operation codes
    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_ARRIVAL   = 2'd0;
    localparam logic [1:0] REG_TOLERANCE = 2'd1;
    localparam logic [1:0] REG_NEAR_ZERO = 2'd2;

    localparam logic [15:0] ARRIVAL_RESET   = 16'd1311;
    localparam logic [13:0] TOLERANCE_RESET = 14'd715;
    localparam logic [15:0] NEAR_ZERO_RESET = 16'd66;

    localparam int CW = 53;   // CORDIC x/y width
    localparam int ZW = 36;   // Q30 angle width
    localparam int MW = 36;   // magnitude width
    localparam int IW = 5;    // CORDIC step index width

    localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic [15:0]          INV_GAIN    = 16'd39797;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] heading;
        logic [62:0]        hold_until;
    } waypoint_t;

    typedef struct packed {
        logic          latch;      // capture the input transaction
        logic          clear;      // begin new path
        logic          append;     // store waypoint
        logic          rd;         // read current or last waypoint
        logic          pre;        // load CORDIC with pre-rotated vector
        logic          iter;       // one CORDIC step
        logic [IW-1:0] iter_idx;
        logic          mag;        // scale magnitude
        logic          decide;     // pick angle difference, advance index
        logic          wrap;       // wrap difference, take magnitude
        logic          fold;       // fold and round to Q2.13
        logic          load;       // load output register with a result
        logic          load_empty; // load output register with an empty result
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       count_zero;
        logic       tracking;
    } dp_status_t;

    function automatic logic [29:0] atan_q30(input logic [IW-1:0] i);
        logic [29:0] r;
        case (i)
            5'd0:    r = 30'd843314856;
            5'd1:    r = 30'd497837829;
            5'd2:    r = 30'd263043836;
            5'd3:    r = 30'd133525158;
            5'd4:    r = 30'd67021686;
            5'd5:    r = 30'd33543515;
            5'd6:    r = 30'd16775850;
            5'd7:    r = 30'd8388437;
            5'd8:    r = 30'd4194282;
            5'd9:    r = 30'd2097149;
            5'd10:   r = 30'd1048575;
            5'd11:   r = 30'd524287;
            5'd12:   r = 30'd262143;
            5'd13:   r = 30'd131071;
            5'd14:   r = 30'd65535;
            5'd15:   r = 30'd32767;
            5'd16:   r = 30'd16383;
            5'd17:   r = 30'd8191;
            5'd18:   r = 30'd4095;
            5'd19:   r = 30'd2047;
            5'd20:   r = 30'd1023;
            5'd21:   r = 30'd511;
            5'd22:   r = 30'd255;
            5'd23:   r = 30'd127;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/wfs_ctrl.sv
// ----------------------------------------------------------------------------
// wfs_ctrl
// Sequencer for the steering block: handshakes and datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module wfs_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire wfs_pkg::dp_status_t status,
    output wfs_pkg::dp_cmd_t         cmd
);
    import wfs_pkg::*;

    `include "waypoint_follow_steering_assert.svh"

    localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_PRE, S_ITER, S_MAG, S_DECIDE,
        S_WRAP, S_FOLD, S_OUT, S_EMPTY
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] iter_reg, iter_next;
    logic          out_valid_reg, out_valid_next;
    logic          slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.iter_idx   = iter_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.op)
                    OP_BEGIN:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    OP_APPEND:
                    begin
                        cmd.append = 1'b1;
                        state_next = S_IDLE;
                    end
                    OP_TICK:
                    begin
                        if (status.count_zero)
                            state_next = S_EMPTY;
                        else
                        begin
                            cmd.rd     = 1'b1;
                            state_next = status.tracking ? S_PRE : S_DECIDE;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_PRE:
            begin
                cmd.pre    = 1'b1;
                iter_next  = '0;
                state_next = S_ITER;
            end
            S_ITER:
            begin
                cmd.iter  = 1'b1;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == LAST_STEP)
                    state_next = S_MAG;
            end
            S_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                cmd.wrap   = 1'b1;
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                if (slot_free)
                begin
                    cmd.load_empty = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `WFS_ASSERT(a_accept_dispatch, (in_valid && in_ready) |=> (state_reg == S_DISPATCH), "accepted transaction not dispatched")
    `WFS_ASSERT(a_iter_range, (state_reg == S_ITER) |-> (iter_reg <= LAST_STEP), "CORDIC step index out of range")
    `WFS_ASSERT(a_load_free, (cmd.load || cmd.load_empty) |-> slot_free, "result loaded over a pending result")

endmodule

`default_nettype wire

### rtl/core/wfs_dp.sv
// ----------------------------------------------------------------------------
// wfs_dp
// Datapath: waypoint memory, CORDIC vectoring unit, turn fold and output.
// ----------------------------------------------------------------------------
`default_nettype none

module wfs_dp #(
    parameter int MAX_WAYPOINTS = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wfs_pkg::dp_cmd_t    cmd,
    output wfs_pkg::dp_status_t      status,
    input  wire logic                cfg_write_en,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire logic [1:0]          operation,
    input  wire logic signed [31:0]  pos_x,
    input  wire logic signed [31:0]  pos_y,
    input  wire logic signed [15:0]  heading,
    input  wire logic [62:0]         time_ns,
    output logic                     valid_res,
    output logic signed [31:0]       forward_target,
    output logic signed [14:0]       turn_target,
    output logic [6:0]               waypoint_index,
    output logic                     holding
);
    import wfs_pkg::*;

    `include "waypoint_follow_steering_assert.svh"

    localparam int AW   = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int NW   = $clog2(MAX_WAYPOINTS + 1);
    localparam logic [NW-1:0] MAX_N = NW'(MAX_WAYPOINTS);

    // Configuration
    logic [15:0] arrival_reg, near_zero_reg;
    logic [13:0] tolerance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arrival_reg   <= ARRIVAL_RESET;
            tolerance_reg <= TOLERANCE_RESET;
            near_zero_reg <= NEAR_ZERO_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_ARRIVAL:   arrival_reg   <= cfg_data;
                REG_TOLERANCE: tolerance_reg <= cfg_data[13:0];
                REG_NEAR_ZERO: near_zero_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Latched transaction
    logic [1:0]         op_reg;
    logic signed [31:0] px_reg, py_reg;
    logic signed [15:0] hd_reg;
    logic [62:0]        tm_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= operation;
            px_reg <= pos_x;
            py_reg <= pos_y;
            hd_reg <= heading;
            tm_reg <= time_ns;
        end
    end

    // Path bookkeeping
    logic [NW-1:0] count_reg, idx_reg;
    logic          tracking;
    logic          advance;
    logic [AW-1:0] rd_addr;

    assign tracking = (idx_reg < count_reg);
    assign rd_addr  = tracking ? AW'(idx_reg) : AW'(count_reg - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (cmd.append && (count_reg < MAX_N))
            count_reg <= count_reg + 1'b1;
        else if (advance)
            idx_reg <= idx_reg + 1'b1;
    end

    assign status.op         = op_reg;
    assign status.count_zero = (count_reg == '0);
    assign status.tracking   = tracking;

    // Waypoint memory
    waypoint_t wp_mem [MAX_WAYPOINTS];
    waypoint_t wp_reg;
    logic      trk_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.append && (count_reg < MAX_N))
            wp_mem[AW'(count_reg)] <= '{px_reg, py_reg, hd_reg, tm_reg};
        if (cmd.rd)
        begin
            wp_reg  <= wp_mem[rd_addr];
            trk_reg <= tracking;
        end
    end

    // CORDIC vectoring
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic signed [32:0]   dx, dy;
    logic signed [CW-1:0] x0, y0, xs, ys;
    logic signed [ZW-1:0] step_ang;

    assign dx = {wp_reg.x[31], wp_reg.x} - {px_reg[31], px_reg};
    assign dy = {wp_reg.y[31], wp_reg.y} - {py_reg[31], py_reg};
    assign x0 = {{4{dx[32]}}, dx, 16'b0};
    assign y0 = {{4{dy[32]}}, dy, 16'b0};
    assign xs = x_reg >>> cmd.iter_idx;
    assign ys = y_reg >>> cmd.iter_idx;
    assign step_ang = ZW'(atan_q30(cmd.iter_idx));

    always_ff @(posedge clk)
    begin
        if (cmd.pre)
        begin
            if (x0 < 0)
            begin
                if (y0 >= 0)
                begin
                    x_reg <= y0;
                    y_reg <= -x0;
                    z_reg <= HALF_PI_Q30;
                end
                else
                begin
                    x_reg <= -y0;
                    y_reg <= x0;
                    z_reg <= -HALF_PI_Q30;
                end
            end
            else
            begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end
        end
        else if (cmd.iter)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + step_ang;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - step_ang;
            end
        end
    end

    // Magnitude: gain-corrected CORDIC x in Q16.16
    logic [MW-1:0] mag_reg;
    logic [43:0]   x_pos;
    logic [59:0]   mag_prod;

    assign x_pos    = x_reg[CW-1] ? 44'd0 : x_reg[51:8];
    assign mag_prod = x_pos * INV_GAIN;

    always_ff @(posedge clk)
    begin
        if (cmd.mag)
            mag_reg <= mag_prod[59:24];
    end

    // Decide: hold, advance and the angle difference to turn through
    logic signed [ZW-1:0] cur_q30, wh_q30, d_reg;
    logic                 close, hold_now;
    logic                 hold_reg, drive_reg, perm_reg, zero_reg;

    assign cur_q30  = {{3{hd_reg[15]}}, hd_reg, 17'b0};
    assign wh_q30   = {{3{wp_reg.heading[15]}}, wp_reg.heading, 17'b0};
    assign close    = (mag_reg < {20'b0, arrival_reg});
    assign hold_now = trk_reg && close && (tm_reg < wp_reg.hold_until);
    assign advance  = cmd.decide && trk_reg && close && !hold_now;

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            hold_reg  <= hold_now;
            drive_reg <= trk_reg && !hold_now;
            if (!trk_reg || hold_now)
            begin
                d_reg    <= wh_q30 - cur_q30;
                perm_reg <= 1'b0;
                zero_reg <= 1'b0;
            end
            else
            begin
                d_reg    <= z_reg - cur_q30;
                perm_reg <= 1'b1;
                zero_reg <= (mag_reg < {20'b0, near_zero_reg});
            end
        end
    end

    // Wrap into (-pi, pi] and take the magnitude
    logic signed [ZW-1:0] d_wrap, a_reg;
    logic                 neg_reg;

    always_comb
    begin
        if (d_reg > PI_Q30)
            d_wrap = d_reg - TWO_PI_Q30;
        else if (d_reg <= -PI_Q30)
            d_wrap = d_reg + TWO_PI_Q30;
        else
            d_wrap = d_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wrap)
        begin
            neg_reg <= d_wrap[ZW-1];
            a_reg   <= d_wrap[ZW-1] ? -d_wrap : d_wrap;
        end
    end

    // Fold past a right angle and round to Q2.13
    logic                 big, s_neg;
    logic signed [ZW-1:0] f_val, f_signed, f_round;
    logic signed [14:0]   turn_reg;
    logic                 dir_neg_reg;

    assign big      = (a_reg > HALF_PI_Q30);
    assign f_val    = big ? (PI_Q30 - a_reg) : a_reg;
    assign s_neg    = neg_reg ^ (perm_reg && big);
    assign f_signed = s_neg ? -f_val : f_val;
    assign f_round  = (f_signed + ZW'(65536)) >>> 17;

    always_ff @(posedge clk)
    begin
        if (cmd.fold)
        begin
            turn_reg    <= zero_reg ? 15'sd0 : f_round[14:0];
            dir_neg_reg <= !zero_reg && perm_reg && big;
        end
    end

    // Forward target with saturation
    logic [14:0]        turn_abs;
    logic               fwd_en, sat;
    logic signed [31:0] fwd;

    assign turn_abs = turn_reg[14] ? 15'(-turn_reg) : 15'(turn_reg);
    assign fwd_en   = drive_reg && (turn_abs < {1'b0, tolerance_reg});
    assign sat      = (mag_reg[MW-1:31] != '0);

    always_comb
    begin
        if (!fwd_en)
            fwd = '0;
        else if (dir_neg_reg)
            fwd = sat ? 32'sh8000_0000 : -$signed(mag_reg[31:0]);
        else
            fwd = sat ? 32'sh7fff_ffff : $signed(mag_reg[31:0]);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_res      <= 1'b0;
            forward_target <= '0;
            turn_target    <= '0;
            waypoint_index <= '0;
            holding        <= 1'b0;
        end
        else if (cmd.load)
        begin
            valid_res      <= 1'b1;
            forward_target <= fwd;
            turn_target    <= turn_reg;
            waypoint_index <= 7'(idx_reg);
            holding        <= hold_reg;
        end
        else if (cmd.load_empty)
        begin
            valid_res      <= 1'b0;
            forward_target <= '0;
            turn_target    <= '0;
            waypoint_index <= '0;
            holding        <= 1'b0;
        end
    end

    `WFS_ASSERT(a_idx_le_count, idx_reg <= count_reg, "waypoint index past count")
    `WFS_ASSERT(a_count_le_max, count_reg <= MAX_N, "waypoint count past capacity")
    `WFS_ASSERT(a_hold_valid, holding |-> valid_res, "holding without a loaded path")

endmodule

`default_nettype wire

### rtl/core/waypoint_follow_steering.sv
// ----------------------------------------------------------------------------
// waypoint_follow_steering
// Waypoint follower: loads a path and steers toward it on every pose tick.
// ----------------------------------------------------------------------------
// One transaction at a time. Begin-path, append and no-op transactions finish
// without giving a result. A pose tick on an empty path gives an empty
// result; otherwise it goes through the iterative CORDIC vectoring unit,
// which does one micro-rotation per cycle. A tick past the last waypoint skips
// the CORDIC. The result sits in an output register; a new transaction is
// accepted while it waits to be taken. Waypoint memory contents are undefined
// until written; no clearing pass is needed.
`default_nettype none

module waypoint_follow_steering #(
    parameter int MAX_WAYPOINTS = 64,
    parameter int CORDIC_STEPS  = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration writes
    input  wire logic               cfg_write_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    // input transactions
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         operation,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [15:0] heading,
    input  wire logic [62:0]        time_ns,
    // result transactions
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    valid_res,
    output logic signed [31:0]      forward_target,
    output logic signed [14:0]      turn_target,
    output logic [6:0]              waypoint_index,
    output logic                    holding
);
    import wfs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer: accepts transactions, steps the datapath, owns result valid
    wfs_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: path memory, CORDIC, fold/round, forward saturation, outputs
    wfs_dp #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .operation      (operation),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .heading        (heading),
        .time_ns        (time_ns),
        .valid_res      (valid_res),
        .forward_target (forward_target),
        .turn_target    (turn_target),
        .waypoint_index (waypoint_index),
        .holding        (holding)
    );

endmodule

`default_nettype wire

### sim/tb_waypoint_follow_steering.sv
// ----------------------------------------------------------------------------
// tb_waypoint_follow_steering
// Self-checking bench for the waypoint steering block: a queue-fed driver
// offers begin/append/tick/no-op transactions, a predictor mirrors the path state
// and CORDIC math, and a monitor compares each result against the oldest
// prediction. Both sides idle in random bursts; the sink holds off once.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_waypoint_follow_steering;
    import wfs_pkg::*;

    localparam int NWP = 64;
    localparam int STEPS = 16;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] hd;
        logic [62:0]        tm;
    } pose_cmd_t;

    typedef struct packed {
        logic               vres;
        logic signed [31:0] fwd;
        logic signed [14:0] turn;
        logic [6:0]         idx;
        logic               hold;
    } steer_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] operation = '0;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [15:0] heading = '0;
    logic [62:0] time_ns = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic valid_res;
    logic signed [31:0] forward_target;
    logic signed [14:0] turn_target;
    logic [6:0] waypoint_index;
    logic holding;

    waypoint_follow_steering dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state: path memory, pointers and register copies
    logic signed [31:0] path_x [NWP];
    logic signed [31:0] path_y [NWP];
    logic signed [15:0] path_hd [NWP];
    logic [62:0] path_hold [NWP];
    int unsigned path_count, path_pos;
    longint radius_q, tol_q, nearz_q;

    pose_cmd_t pending_cmds[$];
    steer_res_t expected_steer[$];
    int unsigned err_count = 0;
    longint cycle_count = 0;
    bit calm = 1'b0;            // no idling in the final stretch
    bit sink_hold = 1'b0;       // request one long receiver hold-off

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_entry(int i);
        longint t[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
            33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
            262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
            255, 127};
        return t[i];
    endfunction

    // CORDIC vectoring: angle in Q30, magnitude in Q16.16
    function automatic void vector_polar(input longint dx, input longint dy,
                                         output longint ang, output longint mag);
        longint x, y, z, t, xs, ys;
        x = dx * 65536;
        y = dy * 65536;
        z = 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = HALF_PI_Q30;
            end
            else
            begin
                t = x; x = -y; y = t; z = -HALF_PI_Q30;
            end
        end
        for (int i = 0; i < STEPS; i++)
        begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; z += atan_entry(i);
            end
            else
            begin
                x -= ys; y += xs; z -= atan_entry(i);
            end
        end
        if (x < 0) x = 0;
        ang = z;
        mag = ((x >>> 8) * 39797) >>> 24;
    endfunction

    // Wrap to (-pi,pi], fold into +-pi/2, round to Q2.13
    function automatic longint fold_to_turn(longint d, bit reverse_ok, output int dir);
        longint a, f;
        int s;
        dir = 1;
        while (d > PI_Q30) d -= TWO_PI_Q30;
        while (d <= -PI_Q30) d += TWO_PI_Q30;
        s = (d < 0) ? -1 : 1;
        a = (d < 0) ? -d : d;
        f = (a > HALF_PI_Q30) ? (PI_Q30 - a) : a;
        if (reverse_ok && a > HALF_PI_Q30)
        begin
            dir = -1;
            s = -s;
        end
        if (s < 0) f = -f;
        return shr_floor(f + 65536, 17);
    endfunction

    function automatic void predict_steer(pose_cmd_t c);
        steer_res_t r;
        longint fwd, turn, cur, ang, mag, t;
        int dir;
        bit close;
        int unsigned k;
        fwd = 0;
        turn = 0;
        r = '0;
        cur = longint'(c.hd) * 131072;
        case (c.op)
            OP_BEGIN:
            begin
                path_count = 0;
                path_pos = 0;
                return;
            end
            OP_APPEND:
            begin
                if (path_count < NWP)
                begin
                    path_x[path_count] = c.x;
                    path_y[path_count] = c.y;
                    path_hd[path_count] = c.hd;
                    path_hold[path_count] = c.tm;
                    path_count++;
                end
                return;
            end
            OP_TICK: ;
            default: return;
        endcase
        if (path_count == 0)
        begin
            expected_steer.push_back(r);
            return;
        end
        if (path_pos < path_count)
        begin
            k = path_pos;
            vector_polar(longint'(path_x[k]) - longint'(c.x),
                         longint'(path_y[k]) - longint'(c.y), ang, mag);
            close = mag < radius_q;
            if (close && c.tm < path_hold[k])
            begin
                r.hold = 1'b1;
                turn = fold_to_turn(longint'(path_hd[k]) * 131072 - cur, 1'b0, dir);
            end
            else
            begin
                if (close) path_pos++;
                dir = 1;
                if (mag < nearz_q) turn = 0;
                else turn = fold_to_turn(ang - cur, 1'b1, dir);
                t = (turn < 0) ? -turn : turn;
                if (t < tol_q)
                begin
                    fwd = (dir < 0) ? -mag : mag;
                    if (fwd > 64'sd2147483647) fwd = 64'sd2147483647;
                    if (fwd < -64'sd2147483648) fwd = -64'sd2147483648;
                end
            end
        end
        else
            turn = fold_to_turn(longint'(path_hd[path_count - 1]) * 131072 - cur,
                                1'b0, dir);
        r.vres = 1'b1;
        r.fwd = fwd[31:0];
        r.turn = turn[14:0];
        r.idx = path_pos[6:0];
        expected_steer.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want,
                 cycle_count);
        err_count++;
    endtask

    function automatic logic signed [15:0] rand_heading();
        return 16'(int'($urandom_range(51472)) - 25736);
    endfunction

    function automatic pose_cmd_t mk(logic [1:0] op, logic signed [31:0] x,
                                     logic signed [31:0] y, logic signed [15:0] h,
                                     logic [62:0] t);
        pose_cmd_t c;
        c.op = op; c.x = x; c.y = y; c.hd = h; c.tm = t;
        return c;
    endfunction

    // Sample in_ready at the rising edge for the falling-edge driver
    logic in_ready_q = 1'b0;
    always @(posedge clk) in_ready_q <= in_ready;

    // Driver: present at falling edge, advance after acceptance
    int unsigned src_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready_q)
            begin
                predict_steer(pending_cmds.pop_front());
            end
            if (!(in_valid && !in_ready_q))
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    in_valid <= 1'b1;
                    operation <= pending_cmds[0].op;
                    pos_x <= pending_cmds[0].x;
                    pos_y <= pending_cmds[0].y;
                    heading <= pending_cmds[0].hd;
                    time_ns <= pending_cmds[0].tm;
                    if (!calm && $urandom_range(7) == 0) src_gap = $urandom_range(1, 11);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare at the rising edge; the sink sets ready at the falling edge
    int unsigned snk_gap = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && out_ready)
        begin
            steer_res_t w;
            if (expected_steer.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                w = expected_steer.pop_front();
                if (valid_res !== w.vres) report_mismatch("valid_res", valid_res, w.vres);
                if (forward_target !== w.fwd)
                    report_mismatch("forward_target", forward_target, w.fwd);
                if (turn_target !== w.turn) report_mismatch("turn_target", turn_target, w.turn);
                if (waypoint_index !== w.idx)
                    report_mismatch("waypoint_index", waypoint_index, w.idx);
                if (holding !== w.hold) report_mismatch("holding", holding, w.hold);
            end
        end
    end

    // Sink: the long hold-off is counted here, once, when requested
    bit hold_done = 1'b0;
    int unsigned hold_left = 0;
    always @(negedge clk)
    begin
        if (sink_hold && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (snk_gap > 0)
        begin
            snk_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(7) == 0) snk_gap = $urandom_range(1, 11);
        end
    end

    // Wait until the block has drained everything queued so far
    task automatic drain();
        while (pending_cmds.size() > 0 || in_valid || expected_steer.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_ARRIVAL: radius_q = longint'(val);
            REG_TOLERANCE: tol_q = longint'(val[13:0]);
            REG_NEAR_ZERO: nearz_q = longint'(val);
            default: ;
        endcase
    endtask

    // One well-formed path plus ticks that walk it, with noise mixed in
    task automatic queue_path(input int npts, input int nticks, input int spread);
        logic signed [31:0] bx, by;
        int k;
        bx = $urandom;
        by = $urandom;
        pending_cmds.push_back(mk(OP_BEGIN, $urandom, $urandom, rand_heading(),
                                  63'({$urandom, $urandom})));
        for (int i = 0; i < npts; i++)
            pending_cmds.push_back(mk(OP_APPEND, bx + $urandom_range(spread) * 256,
                by + $urandom_range(spread) * 256, rand_heading(),
                63'($urandom_range(3) == 0 ? 63'h7FFF_FFFF_FFFF_FFFF : $urandom_range(2000))));
        for (int i = 0; i < nticks; i++)
        begin
            k = $urandom_range(9);
            if (k == 0)
                pending_cmds.push_back(mk(OP_NOP, $urandom, $urandom, rand_heading(),
                                          63'($urandom)));
            else if (k == 1)
                pending_cmds.push_back(mk(OP_TICK, $urandom, $urandom, rand_heading(),
                                          63'({$urandom, $urandom})));
            else
                // mostly ticks near the path so waypoints get reached
                pending_cmds.push_back(mk(OP_TICK, bx + $urandom_range(spread) * 256,
                    by + $urandom_range(spread) * 256, rand_heading(),
                    63'($urandom_range(3000))));
        end
    endtask

    initial
    begin
        path_count = 0;
        path_pos = 0;
        radius_q = ARRIVAL_RESET;
        tol_q = TOLERANCE_RESET;
        nearz_q = NEAR_ZERO_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty path, extremes, hold, goal, append after goal, capacity overflow
        pending_cmds.push_back(mk(OP_TICK, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sd25736, '1));
        pending_cmds.push_back(mk(OP_NOP, '1, '1, -16'sd25736, '1));
        pending_cmds.push_back(mk(OP_APPEND, 0, 0, 16'sd0, 63'd100));
        pending_cmds.push_back(mk(OP_TICK, 0, 0, 16'sd25736, 63'd0));
        pending_cmds.push_back(mk(OP_TICK, 32'sh8000_0000, 32'sh8000_0000, -16'sd25736, 63'd0));
        pending_cmds.push_back(mk(OP_TICK, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sd0, 63'd0));
        pending_cmds.push_back(mk(OP_TICK, 32'sh0001_0000, 0, 16'sd0, 63'd50));
        pending_cmds.push_back(mk(OP_TICK, 32'sh0010_0000, 0, 16'sd0, 63'd50));
        pending_cmds.push_back(mk(OP_TICK, 100, 0, 16'sd100, 63'd200));
        pending_cmds.push_back(mk(OP_TICK, 5, 5, -16'sd12868, 63'd300));
        pending_cmds.push_back(mk(OP_APPEND, 32'sh0100_0000, 0, 16'sd6434, '1));
        pending_cmds.push_back(mk(OP_TICK, 0, 0, 16'sd0, 63'd400));
        pending_cmds.push_back(mk(OP_TICK, 32'sh0200_0000, 0, 16'sd0, 63'd400));
        pending_cmds.push_back(mk(OP_TICK, 0, 32'sh0100_0000, 16'sd0, 63'd400));
        pending_cmds.push_back(mk(OP_BEGIN, 0, 0, 16'sd0, 0));
        for (int i = 0; i < 66; i++)
            pending_cmds.push_back(mk(OP_APPEND, i, -i, 16'(i), 63'd0));
        pending_cmds.push_back(mk(OP_TICK, 0, 0, 16'sd0, 63'd1));
        drain();

        // Random phases over several register settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_ARRIVAL, 16'hFFFF); write_reg(REG_TOLERANCE, 16'd12868);
                         write_reg(REG_NEAR_ZERO, 16'd0); end
                1: begin write_reg(REG_ARRIVAL, 16'd0); write_reg(REG_TOLERANCE, 16'd0);
                         write_reg(REG_NEAR_ZERO, 16'hFFFF); end
                7: begin write_reg(REG_ARRIVAL, 16'd1311); write_reg(REG_TOLERANCE, 16'h3FFF);
                         write_reg(REG_NEAR_ZERO, 16'd66); end
                default: begin write_reg(REG_ARRIVAL, 16'($urandom));
                         write_reg(REG_TOLERANCE, 16'($urandom_range(12868)));
                         write_reg(REG_NEAR_ZERO, 16'($urandom)); end
            endcase
            if (ph == 7) calm = 1'b1;
            for (int p = 0; p < 8; p++)
                queue_path($urandom_range(1, 6), $urandom_range(8, 24),
                           (p % 2) ? 4000 : 40);
            if (ph == 3)
                // Hold the sink off long enough for the block to back up
                sink_hold = 1'b1;
            drain();
        end

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        if (cycle_count > LIMIT)
        begin
            $display("Timeout at cycle %0d", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

### waypoint_follow_steering.f
+incdir+rtl/core
rtl/core/wfs_pkg.sv
rtl/core/wfs_ctrl.sv
rtl/core/wfs_dp.sv
rtl/core/waypoint_follow_steering.sv
sim/tb_waypoint_follow_steering.sv
